[design/tdtsp_pkg.sv]
package tdtsp_pkg;

  // Item action codes.
  localparam logic [1:0] ACT_TOUCH = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_WAKE  = 2'd2;
  localparam logic [1:0] ACT_SLEEP = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_WINDOW  = 1'b1;

  localparam int unsigned CFG_W     = 12;
  localparam int unsigned REMAIN_W  = 22;
  localparam int unsigned TICKS_PER_SECOND = 1000;

  localparam logic [CFG_W-1:0] TIMEOUT_RST = 12'd30;
  localparam logic [CFG_W-1:0] WINDOW_RST  = 12'd300;
  localparam logic [CFG_W-1:0] SINCE_MAX   = 12'hFFF;
  localparam logic [REMAIN_W-1:0] REMAIN_RST = 22'd30000;
  localparam logic [REMAIN_W-1:0] TICKS_PER_SECOND_W = 22'(TICKS_PER_SECOND);

  // One input item.
  typedef struct packed {
    logic [1:0] action;
    logic       pressed;
  } item_t;

  // One result item.
  typedef struct packed {
    logic screen_on;
    logic turned_on;
    logic turned_off;
    logic double_tap_seen;
  } result_t;

endpackage

[design/tdtsp_in_reg.sv]
module tdtsp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tdtsp_pkg::item_t  in_data_i,
  input  logic              down_ready_i,
  output logic              item_valid_o,
  output tdtsp_pkg::item_t  item_o
);

  logic             valid_q, valid_d;
  tdtsp_pkg::item_t item_q;

  // The stage frees up whenever its item moves on in the same cycle.
  assign in_ready_o = !valid_q || down_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[design/tdtsp_core.sv]
module tdtsp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tdtsp_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                          fire_i,
  input  tdtsp_pkg::item_t              item_i,
  output tdtsp_pkg::result_t            result_o
);

  logic [tdtsp_pkg::CFG_W-1:0]    timeout_q, window_q;
  logic                           disp_q, disp_d;
  logic                           prev_q, prev_d;
  logic                           tap_q, tap_d;
  logic [tdtsp_pkg::CFG_W-1:0]    since_q, since_d;
  logic                           armed_q, armed_d;
  logic [tdtsp_pkg::REMAIN_W-1:0] remain_q, remain_d;
  logic [tdtsp_pkg::REMAIN_W-1:0] load_val;
  logic                           restart_en;
  logic                           on_evt, off_evt, dbl;

  // Countdown reload value: seconds times ticks per second, fits 22 bits.
  assign load_val   = tdtsp_pkg::REMAIN_W'(timeout_q) * tdtsp_pkg::TICKS_PER_SECOND_W;
  assign restart_en = (timeout_q != '0);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tdtsp_pkg::TIMEOUT_RST;
      window_q  <= tdtsp_pkg::WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdtsp_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i;
        tdtsp_pkg::CFG_WINDOW:  window_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state and result flags for the item in the input register.
  always_comb begin
    disp_d   = disp_q;
    prev_d   = prev_q;
    tap_d    = tap_q;
    since_d  = since_q;
    armed_d  = armed_q;
    remain_d = remain_q;
    on_evt   = 1'b0;
    off_evt  = 1'b0;
    dbl      = 1'b0;

    unique case (item_i.action)
      tdtsp_pkg::ACT_TOUCH: begin
        if (prev_q && !item_i.pressed && tap_q && (since_q < window_q)) begin
          // Second tap inside the window toggles the screen.
          dbl    = 1'b1;
          prev_d = 1'b0;
          tap_d  = 1'b0;
          if (disp_q) begin
            off_evt = 1'b1;
            disp_d  = 1'b0;
            armed_d = 1'b0;
          end else begin
            on_evt = 1'b1;
            disp_d = 1'b1;
            if (restart_en) begin
              remain_d = load_val;
              armed_d  = 1'b1;
            end
          end
        end else begin
          // A release after a press records a single tap.
          if (prev_q && !item_i.pressed) begin
            tap_d   = 1'b1;
            since_d = '0;
          end
          prev_d = item_i.pressed;
          if (disp_q && restart_en && (item_i.pressed || prev_q)) begin
            remain_d = load_val;
            armed_d  = 1'b1;
          end
        end
      end
      tdtsp_pkg::ACT_TICK: begin
        if (since_q != tdtsp_pkg::SINCE_MAX) begin
          since_d = since_q + 1'b1;
        end
        if (armed_q) begin
          if (remain_q <= tdtsp_pkg::REMAIN_W'(1)) begin
            remain_d = '0;
            armed_d  = 1'b0;
            if (disp_q) begin
              off_evt = 1'b1;
              disp_d  = 1'b0;
              tap_d   = 1'b0;
            end
          end else begin
            remain_d = remain_q - 1'b1;
          end
        end
      end
      tdtsp_pkg::ACT_WAKE: begin
        if (!disp_q) begin
          on_evt = 1'b1;
          disp_d = 1'b1;
          tap_d  = 1'b0;
          if (restart_en) begin
            remain_d = load_val;
            armed_d  = 1'b1;
          end
        end
      end
      tdtsp_pkg::ACT_SLEEP: begin
        if (disp_q) begin
          off_evt = 1'b1;
          disp_d  = 1'b0;
          tap_d   = 1'b0;
          armed_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // State registers advance only when an item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q   <= 1'b1;
      prev_q   <= 1'b0;
      tap_q    <= 1'b0;
      since_q  <= '0;
      armed_q  <= 1'b1;
      remain_q <= tdtsp_pkg::REMAIN_RST;
    end else if (fire_i) begin
      disp_q   <= disp_d;
      prev_q   <= prev_d;
      tap_q    <= tap_d;
      since_q  <= since_d;
      armed_q  <= armed_d;
      remain_q <= remain_d;
    end
  end

  assign result_o.screen_on       = disp_d;
  assign result_o.turned_on       = on_evt;
  assign result_o.turned_off      = off_evt;
  assign result_o.double_tap_seen = dbl;

endmodule

[design/tdtsp_out_reg.sv]
module tdtsp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  tdtsp_pkg::result_t  result_i,
  output logic                down_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tdtsp_pkg::result_t  out_data_o
);

  logic               valid_q, valid_d;
  tdtsp_pkg::result_t data_q;

  // The result register takes a new result when empty or being drained.
  assign down_ready_o = !valid_q || out_ready_i;
  assign valid_d      = down_ready_o ? item_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i && down_ready_o) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[design/touch_double_tap_screen_power_unit.sv]
// Touch double-tap screen power controller.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one item per
// transfer: a touch sample, a millisecond tick, a wake or a sleep command.
// Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
// result per item: the screen state and whether the item turned the screen
// on or off or completed a double-tap. Results come back in item order.
// Each item is registered in the input register, its result in the result
// register. All state update is a single short combinational pass, so
// throughput is one item per cycle while the receiver does not stall. When
// it stalls, the result register holds and the input register takes one
// more item if empty; then in_ready_o drops until the output drains. The
// config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes the timeout (index 0)
// or the tap window (index 1); the user must write it only while idle, as
// the block does not enforce this. Reset turns the screen on, arms a 30
// second countdown, clears tap history and empties both pipeline registers.
module touch_double_tap_screen_power_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [tdtsp_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tdtsp_pkg::item_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tdtsp_pkg::result_t           out_data_o
);

  logic               down_ready;
  logic               item_valid;
  tdtsp_pkg::item_t   item;
  tdtsp_pkg::result_t result;

  // Input register.
  tdtsp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .down_ready_i (down_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // State and update logic; it commits when the item moves to the output.
  tdtsp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (item_valid && down_ready),
    .item_i     (item),
    .result_o   (result)
  );

  // Result register.
  tdtsp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .result_i     (result),
    .down_ready_o (down_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned STALL_LIMIT = 200;

  // Optional long tick run at the start of a random phase.
  typedef enum int unsigned {
    LONG_NONE,
    LONG_EXPIRE
  } long_run_e;

  // One row of the directed table; known rows carry a typed-in result.
  typedef struct packed {
    tdtsp_pkg::item_t   item;
    logic               known;
    tdtsp_pkg::result_t res;
  } row_t;

  localparam tdtsp_pkg::result_t R_NONE     = '{1'b0, 1'b0, 1'b0, 1'b0};
  localparam tdtsp_pkg::result_t R_ON       = '{1'b1, 1'b0, 1'b0, 1'b0};
  localparam tdtsp_pkg::result_t R_OFF      = '{1'b0, 1'b0, 1'b0, 1'b0};
  localparam tdtsp_pkg::result_t R_WAKE     = '{1'b1, 1'b1, 1'b0, 1'b0};
  localparam tdtsp_pkg::result_t R_SLEEP    = '{1'b0, 1'b0, 1'b1, 1'b0};
  localparam tdtsp_pkg::result_t R_DBL_OFF  = '{1'b0, 1'b0, 1'b1, 1'b1};
  localparam tdtsp_pkg::result_t R_DBL_WAKE = '{1'b1, 1'b1, 1'b0, 1'b1};

  localparam int unsigned N_ROWS = 25;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic                        cfg_idx   = tdtsp_pkg::CFG_TIMEOUT;
  logic [tdtsp_pkg::CFG_W-1:0] cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  tdtsp_pkg::item_t            in_data   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  tdtsp_pkg::result_t          out_data;

  // Typed-in expectation travels alongside the item it belongs to.
  logic               row_known = 1'b0;
  tdtsp_pkg::result_t row_res   = R_NONE;

  row_t directed_rows [0:N_ROWS-1];

  // Predicted screen power state and register copies.
  logic [tdtsp_pkg::CFG_W-1:0]    cfg_timeout  = tdtsp_pkg::TIMEOUT_RST;
  logic [tdtsp_pkg::CFG_W-1:0]    cfg_window   = tdtsp_pkg::WINDOW_RST;
  logic                           scr_on       = 1'b1;
  logic                           held         = 1'b0;
  logic                           tap_pending  = 1'b0;
  logic [tdtsp_pkg::CFG_W-1:0]    since_tap_ms = '0;
  logic                           cd_armed     = 1'b1;
  logic [tdtsp_pkg::REMAIN_W-1:0] cd_left      = tdtsp_pkg::REMAIN_RST;

  tdtsp_pkg::result_t power_q [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 1;
  int unsigned wake_count = 0;
  int unsigned sleep_count = 0;
  int unsigned dbl_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned ready_left = 0;

  touch_double_tap_screen_power_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #10 clk = ~clk;

  // A restart loads the full timeout, unless the timeout is zero.
  function automatic void reload_countdown();
    if (cfg_timeout != '0) begin
      cd_left  = tdtsp_pkg::REMAIN_W'(cfg_timeout) *
                 tdtsp_pkg::REMAIN_W'(tdtsp_pkg::TICKS_PER_SECOND);
      cd_armed = 1'b1;
    end
  endfunction

  function automatic logic power_down();
    if (!scr_on) begin
      return 1'b0;
    end
    cd_armed    = 1'b0;
    scr_on      = 1'b0;
    tap_pending = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic power_up();
    if (scr_on) begin
      return 1'b0;
    end
    scr_on      = 1'b1;
    tap_pending = 1'b0;
    reload_countdown();
    return 1'b1;
  endfunction

  // Advances the predicted state by one item and returns its result.
  function automatic tdtsp_pkg::result_t screen_power_next(input tdtsp_pkg::item_t it);
    tdtsp_pkg::result_t r;
    logic               consumed;
    r = R_NONE;
    consumed = 1'b0;
    case (it.action)
      tdtsp_pkg::ACT_TOUCH: begin
        if (held && !it.pressed) begin
          if (tap_pending && since_tap_ms < cfg_window) begin
            r.double_tap_seen = 1'b1;
            if (scr_on) begin
              r.turned_off = power_down();
            end else begin
              r.turned_on = power_up();
            end
            held     = 1'b0;
            consumed = 1'b1;
          end else begin
            if (scr_on) begin
              reload_countdown();
            end
            tap_pending  = 1'b1;
            since_tap_ms = '0;
          end
        end
        if (!consumed) begin
          held = it.pressed;
          if (scr_on && it.pressed) begin
            reload_countdown();
          end
        end
      end
      tdtsp_pkg::ACT_TICK: begin
        if (since_tap_ms != tdtsp_pkg::SINCE_MAX) begin
          since_tap_ms = since_tap_ms + 1'b1;
        end
        if (cd_armed) begin
          if (cd_left <= tdtsp_pkg::REMAIN_W'(1)) begin
            cd_left    = '0;
            cd_armed   = 1'b0;
            r.turned_off = power_down();
          end else begin
            cd_left = cd_left - 1'b1;
          end
        end
      end
      tdtsp_pkg::ACT_WAKE: begin
        r.turned_on = power_up();
      end
      default: begin
        r.turned_off = power_down();
      end
    endcase
    r.screen_on = scr_on;
    return r;
  endfunction

  // Sample both channels and the register port, predict and compare.
  always @(posedge clk) begin : check_proc
    tdtsp_pkg::result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_idx == tdtsp_pkg::CFG_TIMEOUT) begin
          cfg_timeout = cfg_data;
        end else begin
          cfg_window = cfg_data;
        end
      end
      // Compare before pushing so a result never meets its own item.
      if (out_valid && out_ready) begin
        results_seen++;
        if (power_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result transfer %0d arrived with nothing expected: %b",
                     results_seen, out_data);
          end
        end else begin
          want = power_q.pop_front();
          if (out_data.screen_on !== want.screen_on ||
              out_data.turned_on !== want.turned_on ||
              out_data.turned_off !== want.turned_off ||
              out_data.double_tap_seen !== want.double_tap_seen) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result %0d: expected on=%b up=%b down=%b dbl=%b",
                       results_seen, want.screen_on, want.turned_on,
                       want.turned_off, want.double_tap_seen);
              $display("  got on=%b up=%b down=%b dbl=%b",
                       out_data.screen_on, out_data.turned_on,
                       out_data.turned_off, out_data.double_tap_seen);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        want = screen_power_next(in_data);
        if (row_known) begin
          want = row_res;
        end
        power_q.push_back(want);
        wake_count  += want.turned_on;
        sleep_count += want.turned_off;
        dbl_count   += want.double_tap_seen;
      end
      // Watchdog on cycles with no transfer on either channel.
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("No transfer for %0d cycles, %0d results outstanding",
                   idle_cycles, power_q.size());
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Receiver alternates ready stretches and stalls of random length.
  always @(posedge clk) begin
    if (rst_n) begin
      if (ready_left == 0) begin
        if ($urandom_range(0, 2) != 0) begin
          out_ready <= 1'b1;
          ready_left = $urandom_range(1, 60);
        end else begin
          out_ready <= 1'b0;
          ready_left = $urandom_range(1, 12);
        end
      end else begin
        ready_left--;
      end
    end
  end

  // Sender: bursts of transfers separated by short gaps.
  task automatic issue_row(input tdtsp_pkg::item_t it, input logic known,
                           input tdtsp_pkg::result_t res);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_data   <= it;
    row_known <= known;
    row_res   <= res;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic issue(input logic [1:0] act, input logic prs);
    tdtsp_pkg::item_t it;
    it.action  = act;
    it.pressed = prs;
    issue_row(it, 1'b0, R_NONE);
  endtask

  task automatic tick_run(input int unsigned n);
    repeat (n) issue(tdtsp_pkg::ACT_TICK, 1'($urandom_range(0, 1)));
  endtask

  // Drain everything in flight, then write both registers.
  task automatic settle_and_config(input logic [tdtsp_pkg::CFG_W-1:0] t_s,
                                   input logic [tdtsp_pkg::CFG_W-1:0] w_ms);
    in_valid <= 1'b0;
    @(posedge clk);
    while (power_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= tdtsp_pkg::CFG_TIMEOUT;
    cfg_data <= t_s;
    @(posedge clk);
    cfg_idx  <= tdtsp_pkg::CFG_WINDOW;
    cfg_data <= w_ms;
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings_used++;
  endtask

  // One random phase: mostly tap gestures with random timing, plus noise.
  task automatic run_phase(input logic [tdtsp_pkg::CFG_W-1:0] t_s,
                           input logic [tdtsp_pkg::CFG_W-1:0] w_ms,
                           input int unsigned n, input long_run_e long_run);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned span;
    settle_and_config(t_s, w_ms);
    span = (w_ms <= 40) ? int'(w_ms) + 2 : 40;
    if (long_run == LONG_EXPIRE) begin
      // Fresh countdown, then let it run out.
      issue(tdtsp_pkg::ACT_SLEEP, 1'b0);
      issue(tdtsp_pkg::ACT_WAKE, 1'b1);
      tick_run(int'(t_s) * tdtsp_pkg::TICKS_PER_SECOND + 2);
    end
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        issue(tdtsp_pkg::ACT_TOUCH, 1'b1);
        tick_run($urandom_range(0, 3));
        issue(tdtsp_pkg::ACT_TOUCH, 1'b0);
        tick_run($urandom_range(0, span));
        issue(tdtsp_pkg::ACT_TOUCH, 1'b1);
        tick_run($urandom_range(0, 2));
        issue(tdtsp_pkg::ACT_TOUCH, 1'b0);
      end else if (pick < 50) begin
        issue(tdtsp_pkg::ACT_TOUCH, 1'b1);
        tick_run($urandom_range(0, 4));
        issue(tdtsp_pkg::ACT_TOUCH, 1'b0);
        tick_run($urandom_range(0, span));
      end else if (pick < 65) begin
        tick_run($urandom_range(1, 60));
      end else if (pick < 75) begin
        issue(tdtsp_pkg::ACT_WAKE, 1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        issue(tdtsp_pkg::ACT_SLEEP, 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          issue(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    // Directed rows at the reset register values.
    directed_rows = '{
      '{'{tdtsp_pkg::ACT_TICK,  1'b1}, 1'b1, R_ON},       // pressed ignored on a tick
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b1}, 1'b1, R_ON},
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b1}, 1'b1, R_ON},       // held press
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b0}, 1'b1, R_ON},       // first tap
      '{'{tdtsp_pkg::ACT_TICK,  1'b0}, 1'b0, R_NONE},
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b1}, 1'b1, R_ON},
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b0}, 1'b1, R_DBL_OFF},  // double-tap turns off
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b0}, 1'b1, R_OFF},      // no phantom tap after it
      '{'{tdtsp_pkg::ACT_SLEEP, 1'b1}, 1'b1, R_OFF},      // sleep while off
      '{'{tdtsp_pkg::ACT_WAKE,  1'b1}, 1'b1, R_WAKE},
      '{'{tdtsp_pkg::ACT_WAKE,  1'b0}, 1'b1, R_ON},       // wake while on
      '{'{tdtsp_pkg::ACT_SLEEP, 1'b0}, 1'b1, R_SLEEP},
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b1}, 1'b1, R_OFF},
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b0}, 1'b1, R_OFF},      // tap while off
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b1}, 1'b1, R_OFF},
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b0}, 1'b1, R_DBL_WAKE}, // double-tap turns on
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b1}, 1'b1, R_ON},
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b0}, 1'b1, R_ON},
      '{'{tdtsp_pkg::ACT_WAKE,  1'b0}, 1'b1, R_ON},       // keeps the tap history
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b1}, 1'b1, R_ON},
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b0}, 1'b1, R_DBL_OFF},
      '{'{tdtsp_pkg::ACT_WAKE,  1'b0}, 1'b1, R_WAKE},     // clears the tap history
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b1}, 1'b1, R_ON},
      '{'{tdtsp_pkg::ACT_TOUCH, 1'b0}, 1'b1, R_ON},       // single tap only
      '{'{tdtsp_pkg::ACT_SLEEP, 1'b1}, 1'b1, R_SLEEP}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_row(directed_rows[i].item, directed_rows[i].known, directed_rows[i].res);
    end

    // Random phases across register extremes and narrow tap windows.
    run_phase(12'd0,    12'd4095, 200, LONG_NONE);
    run_phase(12'd1,    12'd0,    150, LONG_EXPIRE);
    run_phase(12'd4095, 12'd1,    90,  LONG_NONE);
    run_phase(12'd2,    12'd5,    90,  LONG_NONE);
    run_phase(12'd7,    12'd20,   90,  LONG_NONE);
    run_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 40)), 90, LONG_NONE);

    in_valid <= 1'b0;
    @(posedge clk);
    while (power_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Sent %0d items over %0d register settings, %0d results checked.",
             items_sent, settings_used, results_seen);
    $display("Screen woke %0d times, slept %0d times, %0d double-taps; %0d mismatches.",
             wake_count, sleep_count, dbl_count, mismatches);
    if (mismatches == 0 && power_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[touch_double_tap_screen_power_unit.f]
design/tdtsp_pkg.sv
design/tdtsp_in_reg.sv
design/tdtsp_core.sv
design/tdtsp_out_reg.sv
design/touch_double_tap_screen_power_unit.sv
sim/testbench.sv
